// ===== rtl/rllv_pkg.sv =====
// ----------------------------------------------------------------------------
// rllv_pkg: shared types and constants for the request-log line validator
// Position codes, verb codes and the timestamp template.
// ----------------------------------------------------------------------------
package rllv_pkg;

  localparam int unsigned STAMP_LEN       = 36;
  localparam logic [6:0]  SIGN_POS        = 7'd30;
  localparam logic [7:0]  TAG_RUN_MAX     = 8'd7;
  localparam logic [7:0]  BYTE_DIGITS_MAX = 8'd21;
  localparam logic [7:0]  SECS_DIGITS_MAX = 8'd10;
  localparam logic [7:0]  NANO_DIGITS     = 8'd9;
  localparam logic [63:0] BYTE_COUNT_MAX  = 64'd9223372036854775807;
  localparam logic [63:0] SECONDS_MAX     = 64'd2147483647;

  localparam logic [6:0] POS_FLOW_FIRST = 7'd36;
  localparam logic [6:0] POS_FLOW_RUN   = 7'd37;
  localparam logic [6:0] POS_FLOW_GRAPH = 7'd38;
  localparam logic [6:0] POS_VERB_FIRST = 7'd39;
  localparam logic [6:0] POS_VERB_REST  = 7'd40;
  localparam logic [6:0] POS_ALGO_FIRST = 7'd41;
  localparam logic [6:0] POS_ALGO_RUN   = 7'd42;
  localparam logic [6:0] POS_DIGEST     = 7'd43;
  localparam logic [6:0] POS_CHAT       = 7'd44;
  localparam logic [6:0] POS_BYTES      = 7'd45;
  localparam logic [6:0] POS_SECS       = 7'd46;
  localparam logic [6:0] POS_NANOS      = 7'd47;

  localparam logic [2:0] VERB_GET  = 3'd0;
  localparam logic [2:0] VERB_PUT  = 3'd1;
  localparam logic [2:0] VERB_GIVE = 3'd2;
  localparam logic [2:0] VERB_TAKE = 3'd3;
  localparam logic [2:0] VERB_EAT  = 3'd4;
  localparam logic [2:0] VERB_WRAP = 3'd5;
  localparam logic [2:0] VERB_ROLL = 3'd6;

  localparam logic [1:0] VERDICT_OK    = 2'd0;
  localparam logic [1:0] VERDICT_BAD   = 2'd1;
  localparam logic [1:0] VERDICT_EMPTY = 2'd2;

  typedef struct packed {
    logic [6:0]  pos;
    logic [7:0]  run;
    logic [2:0]  verb;
    logic [3:0]  chat;
    logic [63:0] num;
    logic        too_big;
    logic        failed;
    logic        seen;
  } rllv_state_t;

  function automatic logic [7:0] stamp_lo(input logic [6:0] p);
    case (p)
      7'd0:                         stamp_lo = "2";
      7'd4, 7'd7:                   stamp_lo = "-";
      7'd10, 7'd29:                 stamp_lo = " ";
      7'd13, 7'd16:                 stamp_lo = ":";
      7'd19:                        stamp_lo = ".";
      7'd35:                        stamp_lo = 8'h09;
      default:                      stamp_lo = "0";
    endcase
  endfunction

  function automatic logic [7:0] stamp_hi(input logic [6:0] p);
    case (p)
      7'd0:                         stamp_hi = "5";
      7'd4, 7'd7:                   stamp_hi = "-";
      7'd10, 7'd29:                 stamp_hi = " ";
      7'd13, 7'd16:                 stamp_hi = ":";
      7'd19:                        stamp_hi = ".";
      7'd35:                        stamp_hi = 8'h09;
      7'd5:                         stamp_hi = "1";
      7'd8:                         stamp_hi = "3";
      7'd11:                        stamp_hi = "2";
      7'd14, 7'd17:                 stamp_hi = "5";
      default:                      stamp_hi = "9";
    endcase
  endfunction

  function automatic logic [7:0] verb_char(input logic [2:0] v, input logic [1:0] i);
    logic [31:0] t;
    case (v)
      VERB_GET:  t = "get ";
      VERB_PUT:  t = "put ";
      VERB_GIVE: t = "give";
      VERB_TAKE: t = "take";
      VERB_EAT:  t = "eat ";
      VERB_WRAP: t = "wrap";
      default:   t = "roll";
    endcase
    verb_char = t[8'd31 - {i, 3'd0} -: 8];
  endfunction

  function automatic logic [7:0] verb_len(input logic [2:0] v);
    case (v)
      VERB_GET, VERB_PUT, VERB_EAT: verb_len = 8'd3;
      default:                      verb_len = 8'd4;
    endcase
  endfunction

  function automatic logic [7:0] verb_parts(input logic [2:0] v);
    case (v)
      VERB_GIVE: verb_parts = 8'd2;
      VERB_TAKE: verb_parts = 8'd3;
      default:   verb_parts = 8'd1;
    endcase
  endfunction

endpackage

// ===== rtl/request_log_line_validator_top.sv =====
// ----------------------------------------------------------------------------
// request_log_line_validator_top: request-log stream checker
// Parses tab-separated log lines byte by byte; verdict at end of stream.
// ----------------------------------------------------------------------------
//  channel | signals                            | direction
//  in      | in_valid, in_ready, cmd, data_byte | into block
//  out     | out_valid, out_ready, verdict      | out of block
//
//  One input transfer per cycle: the parser state updates in a single pass
//  through the byte step logic, so a byte is consumed each clock.
//  End of stream loads the output register and resets the parser state.
//  Input is only stalled while a verdict waits and a new end-of-stream
//  arrives; data bytes flow past a pending verdict.
//  rst (synchronous) clears the parser state and out_valid; verdict is not reset.
// ----------------------------------------------------------------------------
module request_log_line_validator_top #(
  parameter int GRAPH_RUN_MAX = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [0:0] cmd,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] verdict
);
  import rllv_pkg::*;

  rllv_state_t st, st_next, stepped;
  logic        take;

  rllv_step #(.GRAPH_RUN_MAX(GRAPH_RUN_MAX)) u_step (
    .cur (st),
    .c   (data_byte),
    .nxt (stepped)
  );

  // a pending verdict only blocks another end-of-stream transfer
  assign in_ready = !out_valid || out_ready || !cmd[0];
  assign take     = in_valid && in_ready;

  always_comb begin
    st_next = st;
    if (take) begin
      if (cmd[0]) st_next = '0;
      else        st_next = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (take && cmd[0]) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd[0]) begin
      if (st.failed)          verdict <= VERDICT_BAD;
      else if (!st.seen)      verdict <= VERDICT_EMPTY;
      else if (st.pos == 7'd0) verdict <= VERDICT_OK;
      else                    verdict <= VERDICT_BAD;
    end
  end

endmodule

// ===== rtl/rllv_step.sv =====
// ----------------------------------------------------------------------------
// rllv_step: next-state logic for one data byte
// Works out the parser state after one byte from the current state.
// ----------------------------------------------------------------------------
module rllv_step #(
  parameter int GRAPH_RUN_MAX = 128
) (
  input  rllv_pkg::rllv_state_t cur,
  input  logic [7:0]            c,
  output rllv_pkg::rllv_state_t nxt
);
  import rllv_pkg::*;

  localparam logic [7:0] GRAPH_MAX = 8'(GRAPH_RUN_MAX);

  logic        ok;
  logic [3:0]  d;
  logic [63:0] lim;
  logic [63:0] lim_div;
  logic [63:0] acc;
  logic        is_dig, is_low, is_graph;
  logic [2:0]  vsel;
  logic [7:0]  run_inc;

  assign is_dig   = (c >= "0") && (c <= "9");
  assign is_low   = (c >= "a") && (c <= "z");
  assign is_graph = (c >= 8'h21) && (c <= 8'h7e);
  assign d        = c[3:0];
  assign lim      = (cur.pos == POS_BYTES) ? BYTE_COUNT_MAX : SECONDS_MAX;
  // (limit - d) / 10 per digit: constant limits, so a small table
  always_comb begin
    case ({cur.pos == POS_BYTES, d})
      5'b1_0000, 5'b1_0001, 5'b1_0010, 5'b1_0011, 5'b1_0100, 5'b1_0101,
      5'b1_0110, 5'b1_0111: lim_div = BYTE_COUNT_MAX / 10;
      5'b1_1000, 5'b1_1001: lim_div = BYTE_COUNT_MAX / 10 - 64'd1;
      5'b0_1000, 5'b0_1001: lim_div = SECONDS_MAX / 10 - 64'd1;
      default:              lim_div = SECONDS_MAX / 10;
    endcase
  end
  assign acc     = (cur.num << 3) + (cur.num << 1) + {60'd0, d};
  assign vsel    = (cur.verb > VERB_ROLL) ? VERB_GET : cur.verb;
  assign run_inc = cur.run + 8'd1;

  always_comb begin
    nxt = cur;
    nxt.seen = 1'b1;
    ok = 1'b0;
    if (cur.pos < 7'(STAMP_LEN)) begin
      ok = (cur.pos == SIGN_POS) ? (c == "+" || c == "-")
                                 : (c >= stamp_lo(cur.pos) && c <= stamp_hi(cur.pos));
      nxt.pos = cur.pos + 7'd1;
    end else begin
      case (cur.pos)
        POS_FLOW_FIRST, POS_ALGO_FIRST: begin
          ok = is_low;
          nxt.pos = cur.pos + 7'd1;
          nxt.run = 8'd0;
        end
        POS_FLOW_RUN, POS_ALGO_RUN: begin
          if (c == ((cur.pos == POS_FLOW_RUN) ? "~" : ":")) begin
            ok = 1'b1;
            nxt.pos = cur.pos + 7'd1;
            nxt.run = 8'd0;
          end else begin
            ok = (is_low || is_dig) && (cur.run < TAG_RUN_MAX);
            nxt.run = run_inc;
          end
        end
        POS_FLOW_GRAPH, POS_DIGEST: begin
          if (c == 8'h09) begin
            ok = 1'b1;
            nxt.pos = cur.pos + 7'd1;
            nxt.run = 8'd0;
            nxt.chat = 4'd0;
          end else begin
            ok = is_graph && (cur.run < GRAPH_MAX);
            nxt.run = run_inc;
          end
        end
        POS_VERB_FIRST: begin
          ok = 1'b1;
          nxt.run = 8'd1;
          nxt.pos = POS_VERB_REST;
          case (c)
            "g":     nxt.verb = VERB_GET;
            "p":     nxt.verb = VERB_PUT;
            "t":     nxt.verb = VERB_TAKE;
            "e":     nxt.verb = VERB_EAT;
            "w":     nxt.verb = VERB_WRAP;
            "r":     nxt.verb = VERB_ROLL;
            default: ok = 1'b0;
          endcase
        end
        POS_VERB_REST: begin
          if (cur.run < verb_len(vsel) && verb_char(vsel, cur.run[1:0]) == c) begin
            ok = 1'b1;
            nxt.run = run_inc;
          end else if (vsel == VERB_GET && cur.run == 8'd1 && c == "i") begin
            ok = 1'b1;
            nxt.verb = VERB_GIVE;
            nxt.run = 8'd2;
          end else if (cur.run == verb_len(vsel) && c == 8'h09) begin
            ok = 1'b1;
            nxt.pos = POS_ALGO_FIRST;
          end
        end
        POS_CHAT: begin
          case (cur.chat)
            4'd0: begin
              ok = (c == "o") || (c == "n");
              nxt.chat = (c == "o") ? 4'd1 : 4'd3;
            end
            4'd1: begin
              ok = (c == "k");
              nxt.chat = 4'd2;
            end
            4'd2: begin
              if (c == 8'h09) begin
                ok = 1'b1;
                nxt.pos = POS_BYTES;
                nxt.run = 8'd0;
                nxt.num = 64'd0;
                nxt.too_big = 1'b0;
              end else begin
                nxt.run = run_inc;
                ok = (c == ",") && (run_inc < verb_parts(vsel));
                nxt.chat = 4'd0;
              end
            end
            4'd3: begin
              ok = (c == "o");
              nxt.chat = 4'd4;
            end
            4'd4: begin
              ok = (c == 8'h09);
              nxt.pos = POS_BYTES;
              nxt.run = 8'd0;
              nxt.num = 64'd0;
              nxt.too_big = 1'b0;
            end
            default: ok = 1'b0;
          endcase
        end
        POS_BYTES, POS_SECS: begin
          if (c == ((cur.pos == POS_BYTES) ? 8'h09 : ".")) begin
            ok = !cur.too_big;
            nxt.pos = cur.pos + 7'd1;
            nxt.run = 8'd0;
            nxt.num = 64'd0;
            nxt.too_big = 1'b0;
          end else begin
            ok = is_dig && (cur.run < ((cur.pos == POS_BYTES) ? BYTE_DIGITS_MAX
                                                              : SECS_DIGITS_MAX));
            nxt.run = run_inc;
            if (cur.too_big || cur.num > lim_div || {60'd0, d} > lim)
              nxt.too_big = 1'b1;
            else
              nxt.num = acc;
          end
        end
        POS_NANOS: begin
          if (c == 8'h0a && cur.run == NANO_DIGITS) begin
            ok = 1'b1;
            nxt.pos = 7'd0;
            nxt.run = 8'd0;
          end else begin
            ok = is_dig && (cur.run < NANO_DIGITS);
            nxt.run = run_inc;
          end
        end
        default: ok = 1'b0;
      endcase
    end
    if (cur.failed || !ok) begin
      nxt = cur;
      nxt.seen = 1'b1;
      nxt.failed = 1'b1;
    end
  end

endmodule

// ===== sim/request_log_line_validator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// request_log_line_validator_top_tb: self-checking bench for the log validator
// Feeds request-log streams byte by byte (edge cases, directed lines, stall tests and random lines
// with random corruption), predicts each end-of-stream verdict in the bench
// and checks every verdict transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module request_log_line_validator_top_tb;
  import rllv_pkg::*;

  typedef logic [7:0] bytes_q_t[$];

  localparam int GRAPH_MAX   = 128;
  localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
  localparam int LONG_HOLD   = 300;    // receiver hold-off for the stall test

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [0:0] cmd = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] verdict;

  request_log_line_validator_top #(.GRAPH_RUN_MAX(GRAPH_MAX)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .verdict(verdict)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench copy of the parser state
  // --------------------------------------------------------------------------
  logic [6:0]  line_pos;
  logic [7:0]  run_cnt;
  logic [2:0]  verb_code;
  logic [3:0]  chat_phase;
  logic [63:0] acc_val;
  logic        acc_over;
  logic        err_latched;
  logic        byte_seen;

  logic [1:0] verdicts_due[$];   // expected verdicts, oldest first

  // timestamp template; the sign column is handled on its own
  string stamp_min = "2000-00-00 00:00:00.000000000 +0000\t";
  string stamp_max = "5999-19-39 29:59:59.999999999 -9999\t";
  string verb_names[7] = '{"get", "put", "give", "take", "eat", "wrap", "roll"};
  string tag_chars = "abcdefghijklmnopqrstuvwxyz0123456789";

  int fail_cnt;
  int n_items, n_verdicts, n_good, n_bad, n_empty;
  bit no_idle;          // stretch with back-to-back transfers
  int rx_hold;          // long receiver hold-off request

  function automatic logic [7:0] parts_allowed(logic [2:0] v);
    if (v == VERB_GIVE) return 8'd2;
    if (v == VERB_TAKE) return 8'd3;
    return 8'd1;
  endfunction

  function automatic logic [7:0] name_len(logic [2:0] v);
    return 8'(verb_names[v].len());
  endfunction

  function automatic void clear_parser();
    line_pos = '0; run_cnt = '0; verb_code = '0; chat_phase = '0;
    acc_val = '0; acc_over = 1'b0; err_latched = 1'b0; byte_seen = 1'b0;
  endfunction

  function automatic void add_digit(logic [7:0] c, logic [63:0] limit);
    logic [63:0] d;
    d = 64'(c - "0");
    if (acc_over || acc_val > (limit - d) / 10) acc_over = 1'b1;
    else acc_val = acc_val * 10 + d;
  endfunction

  function automatic void open_number(logic [6:0] p);
    line_pos = p; run_cnt = '0; acc_val = '0; acc_over = 1'b0;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_low(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  // chat history: ok / no, chained with "ok," up to the verb's part count
  function automatic bit chat_accept(logic [7:0] c);
    case (chat_phase)
      4'd0: begin
        if (c == "o") begin chat_phase = 4'd1; return 1; end
        if (c == "n") begin chat_phase = 4'd3; return 1; end
        return 0;
      end
      4'd1: begin
        if (c != "k") return 0;
        chat_phase = 4'd2; return 1;
      end
      4'd2: begin
        if (c == 8'h09) begin open_number(POS_BYTES); return 1; end
        if (c != ",") return 0;
        run_cnt++;
        if (run_cnt >= parts_allowed(verb_code)) return 0;
        chat_phase = 4'd0; return 1;
      end
      4'd3: begin
        if (c != "o") return 0;
        chat_phase = 4'd4; return 1;
      end
      4'd4: begin
        if (c != 8'h09) return 0;
        open_number(POS_BYTES); return 1;
      end
      default: return 0;
    endcase
  endfunction

  // one byte through the line grammar; 0 means the byte is an error
  function automatic bit parse_byte(logic [7:0] c);
    logic [6:0] p;
    logic [7:0] n;
    p = line_pos;
    if (p < STAMP_LEN) begin
      if (p == SIGN_POS) begin
        if (c != "+" && c != "-") return 0;
      end else if (c < stamp_min[p] || c > stamp_max[p]) return 0;
      line_pos = p + 7'd1;
      return 1;
    end
    case (p)
      POS_FLOW_FIRST, POS_ALGO_FIRST: begin
        if (!is_low(c)) return 0;
        line_pos = p + 7'd1; run_cnt = '0; return 1;
      end
      POS_FLOW_RUN, POS_ALGO_RUN: begin
        if (c == ((p == POS_FLOW_RUN) ? "~" : ":")) begin
          line_pos = p + 7'd1; run_cnt = '0; return 1;
        end
        if (!(is_low(c) || is_dig(c)) || run_cnt >= TAG_RUN_MAX) return 0;
        run_cnt++; return 1;
      end
      POS_FLOW_GRAPH, POS_DIGEST: begin
        if (c == 8'h09) begin
          line_pos = p + 7'd1; run_cnt = '0; chat_phase = '0; return 1;
        end
        if (c < 8'h21 || c > 8'h7e || run_cnt >= GRAPH_MAX) return 0;
        run_cnt++; return 1;
      end
      POS_VERB_FIRST: begin
        for (int v = 0; v < 7; v++) begin
          if (3'(v) != VERB_GIVE && verb_names[v][0] == c) begin
            verb_code = 3'(v); run_cnt = 8'd1; line_pos = POS_VERB_REST;
            return 1;
          end
        end
        return 0;
      end
      POS_VERB_REST: begin
        n = name_len(verb_code);
        if (run_cnt < n && verb_names[verb_code][run_cnt[1:0]] == c) begin
          run_cnt++; return 1;
        end
        // "g" may still turn into give
        if (verb_code == VERB_GET && run_cnt == 8'd1 && c == "i") begin
          verb_code = VERB_GIVE; run_cnt = 8'd2; return 1;
        end
        if (run_cnt == n && c == 8'h09) begin
          line_pos = POS_ALGO_FIRST; return 1;
        end
        return 0;
      end
      POS_CHAT: return chat_accept(c);
      POS_BYTES: begin
        if (c == 8'h09) begin
          if (acc_over) return 0;
          open_number(POS_SECS); return 1;
        end
        if (!is_dig(c) || run_cnt >= BYTE_DIGITS_MAX) return 0;
        run_cnt++; add_digit(c, BYTE_COUNT_MAX); return 1;
      end
      POS_SECS: begin
        if (c == ".") begin
          if (acc_over) return 0;
          line_pos = POS_NANOS; run_cnt = '0; return 1;
        end
        if (!is_dig(c) || run_cnt >= SECS_DIGITS_MAX) return 0;
        run_cnt++; add_digit(c, SECONDS_MAX); return 1;
      end
      POS_NANOS: begin
        if (c == 8'h0a && run_cnt == NANO_DIGITS) begin
          line_pos = '0; run_cnt = '0; return 1;
        end
        if (!is_dig(c) || run_cnt >= NANO_DIGITS) return 0;
        run_cnt++; return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void predict_transfer(logic c, logic [7:0] b);
    if (!c) begin
      byte_seen = 1'b1;
      if (!err_latched && !parse_byte(b)) err_latched = 1'b1;
    end else begin
      if (err_latched) verdicts_due.push_back(VERDICT_BAD);
      else if (!byte_seen) verdicts_due.push_back(VERDICT_EMPTY);
      else verdicts_due.push_back(line_pos == '0 ? VERDICT_OK : VERDICT_BAD);
      clear_parser();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one transfer; valid stays up across back-to-back items
  task automatic send_item(logic c, logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_transfer(c, b);
    n_items++;
  endtask

  task automatic send_bytes(bytes_q_t q);
    foreach (q[i]) send_item(1'b0, q[i]);
  endtask

  // end of stream; data_byte is a don't-care, so fill it with noise
  task automatic send_eos();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  // --------------------------------------------------------------------------
  // Line builders
  // --------------------------------------------------------------------------
  function automatic void put_str(ref bytes_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void put_run(ref bytes_q_t q);
    int len;
    len = ($urandom_range(0, 11) == 0) ? GRAPH_MAX : $urandom_range(0, 12);
    repeat (len) q.push_back(8'($urandom_range(8'h21, 8'h7e)));
  endfunction

  function automatic void put_tag(ref bytes_q_t q, input logic [7:0] stop);
    q.push_back(8'($urandom_range("a", "z")));
    repeat ($urandom_range(0, 7)) q.push_back(tag_chars[$urandom_range(0, 35)]);
    q.push_back(stop);
  endfunction

  function automatic void put_number(ref bytes_q_t q, input string top, input string over,
                                     input int width);
    string s;
    case ($urandom_range(0, 9))
      0: s = "";
      1: s = top;
      2: s = over;                                   // one past the limit
      3: begin
        s = $sformatf("%0d", $urandom_range(0, 999));
        while (s.len() < width) s = {"0", s};        // leading zeros, full width
      end
      default: s = $sformatf("%0d", $urandom_range(0, 99999));
    endcase
    put_str(q, s);
  endfunction

  function automatic void put_line(ref bytes_q_t q);
    int v, k;
    for (int p = 0; p < STAMP_LEN; p++) begin
      if (p == SIGN_POS) q.push_back($urandom_range(0, 1) ? "+" : "-");
      else q.push_back(8'($urandom_range(stamp_min[p], stamp_max[p])));
    end
    put_tag(q, "~"); put_run(q); q.push_back(8'h09);
    v = $urandom_range(0, 6);
    put_str(q, verb_names[v]); q.push_back(8'h09);
    put_tag(q, ":"); put_run(q); q.push_back(8'h09);
    // usually a legal chat length for the verb, sometimes one too many
    k = $urandom_range(1, parts_allowed(3'(v)) + ($urandom_range(0, 7) == 0));
    repeat (k - 1) put_str(q, "ok,");
    put_str(q, $urandom_range(0, 1) ? "ok" : "no");
    q.push_back(8'h09);
    put_number(q, "9223372036854775807", "9223372036854775808", 21);
    q.push_back(8'h09);
    put_number(q, "2147483647", "2147483648", 10);
    q.push_back(".");
    repeat (9) q.push_back(8'($urandom_range("0", "9")));
    q.push_back(8'h0a);
  endfunction

  // damage a well-formed line: replace one byte, flip one bit, insert NUL, or cut it short
  function automatic void damage(ref bytes_q_t q);
    int at;
    at = $urandom_range(0, q.size() - 1);
    case ($urandom_range(0, 3))
      0: q[at] = 8'($urandom_range(0, 255));
      1: q.insert(at, 8'h00);
      2: q = q[0:at];
      default: q[at] = q[at] ^ (8'h01 << $urandom_range(0, 7));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        // long hold-off: a pending verdict stays in its register and end-of-stream input backs up
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        gap = no_idle ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    logic [1:0] want;
    if (!rst && out_valid && out_ready) begin
      n_verdicts++;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict transfer, actual %0d", $time, verdict);
        fail_cnt++;
      end else begin
        want = verdicts_due.pop_front();
        if (verdict !== want) begin
          $display("%0t: verdict mismatch, expected %0d actual %0d", $time, want, verdict);
          fail_cnt++;
        end
        case (want)
          VERDICT_OK:  n_good++;
          VERDICT_BAD: n_bad++;
          default:     n_empty++;
        endcase
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  localparam string MIN_LINE =
    "2000-00-00 00:00:00.000000000 +0000\ta~\tget\ta:\tok\t\t.000000000\n";

  // empty streams, stray NUL, a lone newline, a stray 0xff byte
  task automatic test_edge_streams();
    send_eos();
    send_eos();
    send_item(1'b0, 8'h00); send_eos();
    send_item(1'b0, 8'h0a); send_eos();
    send_item(1'b0, 8'hff); send_eos();
  endtask

  // shortest line, extreme stamp and number values, overflow, too many chat parts, unfinished line
  task automatic test_directed_lines();
    send_text(MIN_LINE); send_eos();
    send_text({"5999-19-39 29:59:59.999999999 -9999\tz9999999~~\tgive\t",
               "z0000000:!\tok,no\t9223372036854775807\t2147483647.999999999\n"});
    send_text(MIN_LINE); send_eos();
    send_text({"2000-00-00 00:00:00.000000000 +0000\ta~\ttake\ta:\tok,ok,ok\t",
               "000000000000000000001\t0000000001.123456789\n"});
    send_eos();
    send_text({"2000-00-00 00:00:00.000000000 +0000\ta~\tput\ta:\tok\t",
               "9223372036854775808\t1.000000000\n"});
    send_eos();
    send_text({"2000-00-00 00:00:00.000000000 +0000\ta~\troll\ta:\tno\t",
               "1\t2147483648.000000000\n"});
    send_eos();
    send_text({"2000-00-00 00:00:00.000000000 +0000\ta~\twrap\ta:\tok,ok\t1\t1.000000000\n"});
    send_eos();
    send_text({"2000-00-00 00:00:00.000000000 +0000\ta~\teat\ta:\tno\t1\t1.000000000"});
    send_eos();
  endtask

  // random streams: mostly whole lines, some damaged, some noise and empties
  task automatic test_random_streams(int item_goal, int verdict_goal);
    bytes_q_t q;
    int kind;
    while (n_items < item_goal || n_verdicts + verdicts_due.size() < verdict_goal) begin
      no_idle = ($urandom_range(0, 4) == 0);
      q = {};
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        repeat ($urandom_range(1, 2)) put_line(q);
        if (kind >= 10) damage(q);
      end else if (kind < 17) begin
        repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
      end
      send_bytes(q);
      send_eos();
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while ends of stream keep coming: input must stall
  task automatic test_output_stall();
    bytes_q_t q;
    rx_hold = LONG_HOLD;
    send_eos();
    send_eos();
    put_line(q);
    send_bytes(q);
    send_eos();
    send_eos();
  endtask

  initial begin
    fail_cnt = 0; n_items = 0; n_verdicts = 0;
    n_good = 0; n_bad = 0; n_empty = 0;
    no_idle = 1'b0; rx_hold = 0;
    clear_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_streams();
    test_directed_lines();
    test_output_stall();
    test_random_streams(1700, 60);
    test_output_stall();

    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d transfers in, %0d verdicts out (%0d good, %0d malformed, %0d empty).",
             n_items, n_verdicts, n_good, n_bad, n_empty);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("FAIL");
    end
    $finish;
  end

endmodule
